// ===== sv/me2d_pkg.sv =====
package me2d_pkg;

   // Field widths of the channels.
   localparam int MANT_W = 64;
   localparam int EXP_W  = 16;
   localparam int FRAC_W = 52;
   localparam int BEXP_W = 11;
   localparam int LZC_W  = 6;

   typedef logic signed [MANT_W-1:0] mantissa_type;
   typedef logic signed [EXP_W-1:0]  exponent_type;
   typedef logic [MANT_W-1:0]        magnitude_type;
   typedef logic [MANT_W-1:0]        double_type;
   typedef logic [LZC_W-1:0]         lzc_type;

   // Exponent range of normal binary64 values and the bias.
   localparam exponent_type EXP_MIN  = -16'sd1022;
   localparam exponent_type EXP_MAX  = 16'sd1023;
   localparam exponent_type EXP_BIAS = 16'sd1023;

   // Magnitudes substituted when the exponent is out of range.
   localparam magnitude_type HIDDEN_ONE = 64'h0010_0000_0000_0000;
   localparam magnitude_type MAX_MAG    = 64'h001F_FFFF_FFFF_FFFF;

   // Payload carried between the first and the later stages.
   typedef struct packed {
      logic          sign;
      logic          zero;
      logic          ok;
      logic [BEXP_W-1:0] bexp;
      magnitude_type mag;
   } stage_type;

endpackage

// ===== sv/me2d_if.sv =====
interface me2d_req_if;
   logic                   valid;
   logic                   ready;
   me2d_pkg::mantissa_type mantissa;
   me2d_pkg::exponent_type exponent;

   modport source (output valid, output mantissa, output exponent, input ready);
   modport sink (input valid, input mantissa, input exponent, output ready);
endinterface

interface me2d_rsp_if;
   logic                 valid;
   logic                 ready;
   me2d_pkg::double_type double_bits;
   logic                 ok;

   modport source (output valid, output double_bits, output ok, input ready);
   modport sink (input valid, input double_bits, input ok, output ready);
endinterface

// ===== sv/mantissa_exponent_to_double.sv =====
// Packs a signed 64-bit integer mantissa and a signed 16-bit exponent into an
// IEEE 754 binary64 pattern. The leading one of the mantissa's magnitude
// becomes the hidden bit, lower bits are truncated, and the exponent is used
// as given (it is not adjusted by the normalizing shift). A zero mantissa
// gives +0 with ok set; an exponent below -1022 gives the smallest normal
// value and one above 1023 gives the largest finite value with ok cleared.
// The block is a three-stage pipeline (magnitude and range check, leading
// zero count, normalizing shift and pack): it accepts one item per clock while
// no stall holds the pipeline, and each result is registered in the third
// stage, whose register drives the output.
// A stall on the result side holds the full stages in place while empty
// stages ahead of them still fill up.
module mantissa_exponent_to_double (
   input logic             clock,
   input logic             reset,
   me2d_req_if.sink        req_ch,
   me2d_rsp_if.source      rsp_ch
);
   import me2d_pkg::*;

   // Count leading zeros: eight groups of eight, then pick the first group.
   function automatic lzc_type count_lz(input magnitude_type v);
      logic [7:0]   grp_any;
      logic [2:0]   grp_lz [8];
      logic [2:0]   grp_sel;
      logic         found;
      lzc_type      res;
      grp_any = '0;
      grp_sel = '0;
      found   = 1'b0;
      for (int g = 0; g < 8; g++) begin
         grp_lz[g] = '0;
         grp_any[g] = |v[63-8*g -: 8];
         for (int b = 0; b < 8; b++) begin
            if (v[63-8*g-7+b]) begin
               grp_lz[g] = 3'(7 - b);
            end
         end
      end
      for (int g = 0; g < 8; g++) begin
         if (grp_any[g] && !found) begin
            grp_sel = 3'(g);
            found   = 1'b1;
         end
      end
      res = {grp_sel, grp_lz[grp_sel]};
      return res;
   endfunction

   // Stage valids and payload registers.
   logic      s1_valid_ff, s1_valid_in;
   logic      s2_valid_ff, s2_valid_in;
   logic      s3_valid_ff, s3_valid_in;
   stage_type s1_ff, s1_in;
   stage_type s2_ff;
   lzc_type   s2_lz_ff, s2_lz_in;
   double_type s3_bits_ff, s3_bits_in;
   logic      s3_ok_ff, s3_ok_in;

   logic adv1, adv2, adv3;

   // A stage advances when it is empty or the stage after it advances.
   assign adv3 = !s3_valid_ff || rsp_ch.ready;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_ch.ready = adv1;

   assign s1_valid_in = adv1 ? req_ch.valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;

   // Stage one: sign, magnitude and range check of the exponent.
   always_comb begin
      exponent_type e_use;
      s1_in.sign = req_ch.mantissa[MANT_W-1];
      s1_in.zero = (req_ch.mantissa == '0);
      s1_in.ok   = 1'b1;
      s1_in.mag  = req_ch.mantissa[MANT_W-1] ? magnitude_type'(-req_ch.mantissa)
                                              : magnitude_type'(req_ch.mantissa);
      e_use      = req_ch.exponent;
      if (req_ch.exponent < EXP_MIN) begin
         e_use     = EXP_MIN;
         s1_in.mag = HIDDEN_ONE;
      end
      if (req_ch.exponent > EXP_MAX) begin
         e_use     = EXP_MAX;
         s1_in.mag = MAX_MAG;
         s1_in.ok  = 1'b0;
      end
      s1_in.bexp = BEXP_W'(e_use + EXP_BIAS);
   end

   // Stage two: position of the leading one.
   assign s2_lz_in = count_lz(s1_ff.mag);

   // Stage three: shift the leading one to the top and pack the fields.
   always_comb begin
      magnitude_type norm;
      norm = s2_ff.mag << s2_lz_ff;
      if (s2_ff.zero) begin
         s3_bits_in = '0;
         s3_ok_in   = 1'b1;
      end else begin
         s3_bits_in = {s2_ff.sign, s2_ff.bexp, norm[MANT_W-2 -: FRAC_W]};
         s3_ok_in   = s2_ff.ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Payload registers load only when their stage advances.
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff <= s1_in;
      end
      if (adv2) begin
         s2_ff    <= s1_ff;
         s2_lz_ff <= s2_lz_in;
      end
      if (adv3) begin
         s3_bits_ff <= s3_bits_in;
         s3_ok_ff   <= s3_ok_in;
      end
   end

   assign rsp_ch.valid       = s3_valid_ff;
   assign rsp_ch.double_bits = s3_bits_ff;
   assign rsp_ch.ok          = s3_ok_ff;

`ifndef SYNTHESIS
   // A saturated result carries the largest finite exponent.
   a_sat_exp: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ok |-> rsp_ch.double_bits[62:52] == 11'h7FE)
      else $error("saturated result has wrong exponent");

   // A saturated result carries an all-ones fraction.
   a_sat_frac: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ok |-> &rsp_ch.double_bits[51:0])
      else $error("saturated result has wrong fraction");

   // A zero biased exponent only appears for the +0 result.
   a_zero_only: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.double_bits[62:52] == 11'h000
      |-> rsp_ch.double_bits == 64'h0 && rsp_ch.ok)
      else $error("subnormal or signed zero produced");
`endif

endmodule

// ===== bench/double_pack_check.sv =====
`timescale 1ns / 1ps

module double_pack_check (
   input  logic  clock,
   input  logic  reset,
   me2d_req_if   req,
   me2d_rsp_if   rsp,
   output int    mismatch_count,
   output int    doubles_pending
);
   import me2d_pkg::*;

   typedef struct packed {
      double_type bits;
      logic       ok;
   } packed_double_type;

   packed_double_type expected_doubles[$];
   packed_double_type want;

   // Pack a mantissa and exponent into the binary64 pattern and overflow flag.
   function automatic packed_double_type predict_double(input mantissa_type m,
                                                       input exponent_type e);
      packed_double_type r;
      magnitude_type     mag;
      logic [BEXP_W-1:0] bexp;
      int                ex;
      int                top;
      r.ok   = 1'b1;
      r.bits = '0;
      if (m == 0) begin
         return r;
      end
      // The magnitude is unsigned, so the most negative mantissa gives 2^63.
      mag = m[MANT_W-1] ? ~magnitude_type'(m) + 64'd1 : magnitude_type'(m);
      ex  = int'(e);
      // Out-of-range exponents clamp to the smallest normal or saturate.
      if (ex < int'(EXP_MIN)) begin
         ex  = int'(EXP_MIN);
         mag = HIDDEN_ONE;
      end
      if (ex > int'(EXP_MAX)) begin
         ex   = int'(EXP_MAX);
         mag  = MAX_MAG;
         r.ok = 1'b0;
      end
      // Move the leading one to the hidden-bit position; right shifts truncate.
      top = 0;
      for (int i = 0; i < MANT_W; i++) begin
         if (mag[i]) begin
            top = i;
         end
      end
      if (top > FRAC_W) begin
         mag = mag >> (top - FRAC_W);
      end else begin
         mag = mag << (FRAC_W - top);
      end
      bexp   = BEXP_W'(ex + int'(EXP_BIAS));
      r.bits = {m[MANT_W-1], bexp, mag[FRAC_W-1:0]};
      return r;
   endfunction

   // Count a failure and describe it while the report budget lasts.
   task automatic flag_failure(input string what, input double_type exp_val,
                               input double_type act_val);
      if (mismatch_count < 10) begin
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, what,
                  exp_val, act_val);
      end
      mismatch_count++;
   endtask

   initial begin
      mismatch_count  = 0;
      doubles_pending = 0;
   end

   // Record every accepted item and compare every accepted result in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            expected_doubles.push_back(predict_double(req.mantissa, req.exponent));
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_doubles.size() == 0) begin
               flag_failure("unexpected result", '0, rsp.double_bits);
            end else begin
               want = expected_doubles.pop_front();
               if (rsp.double_bits !== want.bits) begin
                  flag_failure("double_bits", want.bits, rsp.double_bits);
               end
               if (rsp.ok !== want.ok) begin
                  flag_failure("ok", double_type'(want.ok), double_type'(rsp.ok));
               end
            end
         end
      end
      doubles_pending <= expected_doubles.size();
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import me2d_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   doubles_pending;
   int   cycle_count = 0;
   int   idle_pct;
   int   stall_pct;
   int   hold_left = 0;
   bit   hold_req;

   me2d_req_if req_ch ();
   me2d_rsp_if rsp_ch ();

   mantissa_exponent_to_double dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   double_pack_check pack_check (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .rsp             (rsp_ch),
      .mismatch_count  (mismatch_count),
      .doubles_pending (doubles_pending)
   );

   always #5 clock = ~clock;

   // Give up if the run takes far longer than the slowest correct one.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (hold_req) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         hold_req     <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Offer one item after a random gap and wait until it is taken.
   task automatic offer(input mantissa_type m, input exponent_type e);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.mantissa <= m;
      req_ch.exponent <= e;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   // Stop sending until every expected result has come back.
   task automatic drain;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (doubles_pending != 0) begin
         @(posedge clock);
      end
   endtask

   // Mostly magnitudes of random length, some full-width and corner values.
   task automatic random_items(input int count);
      mantissa_type  m;
      exponent_type  e;
      magnitude_type raw;
      repeat (count) begin
         raw = {$urandom(), $urandom()};
         case ($urandom_range(0, 9))
            0: begin
               m = raw;
            end
            1: begin
               case ($urandom_range(0, 3))
                  0: m = '0;
                  1: m = 64'sh8000_0000_0000_0000;
                  2: m = 64'sd1;
                  default: m = -64'sd1;
               endcase
            end
            default: begin
               m = raw >> $urandom_range(0, 63);
               if ($urandom_range(0, 1) == 1) begin
                  m = -m;
               end
            end
         endcase
         case ($urandom_range(0, 9))
            0: begin
               e = exponent_type'($urandom());
            end
            1: begin
               case ($urandom_range(0, 5))
                  0: e = EXP_MIN;
                  1: e = EXP_MIN - 16'sd1;
                  2: e = EXP_MAX;
                  3: e = EXP_MAX + 16'sd1;
                  4: e = 16'sh8000;
                  default: e = 16'sh7FFF;
               endcase
            end
            default: begin
               e = exponent_type'(int'($urandom_range(0, 2200)) - 1100);
            end
         endcase
         offer(m, e);
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.mantissa = '0;
      req_ch.exponent = '0;
      rsp_ch.ready    = 1'b0;
      idle_pct        = 0;
      stall_pct       = 0;
      hold_req        = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero mantissa, whatever the exponent.
      offer(64'sd0, 16'sd0);
      offer(64'sd0, 16'sh7FFF);
      offer(64'sd0, 16'sh8000);
      // Unit magnitudes and the extremes of the mantissa.
      offer(64'sd1, 16'sd0);
      offer(-64'sd1, 16'sd0);
      offer(64'sh7FFF_FFFF_FFFF_FFFF, 16'sd0);
      offer(64'sh8000_0000_0000_0000, 16'sd5);
      offer(64'sh8000_0000_0000_0000, EXP_MAX + 16'sd1);
      offer(64'sh8000_0000_0000_0000, 16'sh8000);
      // Already normalized, widest exact value, and truncation by one bit.
      offer(64'sh0010_0000_0000_0000, 16'sd0);
      offer(64'sh001F_FFFF_FFFF_FFFF, -16'sd1);
      offer(64'sh0020_0000_0000_0001, 16'sd1);
      // Exponent limits: last in range on each side and first beyond.
      offer(64'sd3, EXP_MIN);
      offer(64'sd3, EXP_MIN - 16'sd1);
      offer(-64'sd5, EXP_MIN - 16'sd1);
      offer(64'sd5, EXP_MAX);
      offer(64'sd5, EXP_MAX + 16'sd1);
      offer(-64'sd7, EXP_MAX + 16'sd1);
      offer(-64'sd9, 16'sh8000);
      offer(64'sd9, 16'sh7FFF);
      // Alternating bit patterns of both signs.
      offer(64'sh5555_5555_5555_5555, -16'sd1);
      offer(-64'sh5555_5555_5555_5555, 16'sd200);
      offer(64'shAAAA_AAAA_AAAA_AAAA, -16'sd300);
      drain();

      // Random phases with different amounts of idling on each side.
      random_items(300);
      idle_pct = 71;
      random_items(300);
      idle_pct  = 0;
      stall_pct = 71;
      random_items(300);
      idle_pct  = 14;
      stall_pct = 14;
      random_items(300);

      // Hold the result side off while the input keeps offering items.
      idle_pct  = 0;
      stall_pct = 0;
      hold_req  = 1'b1;
      random_items(60);
      drain();

      idle_pct  = 30;
      stall_pct = 30;
      random_items(165);
      drain();

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && doubles_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/me2d_pkg.sv
sv/me2d_if.sv
sv/mantissa_exponent_to_double.sv
bench/double_pack_check.sv
bench/tb.sv
